// File: src/idct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idct_pkg: shared constants and the cosine table for the 8x8 IDCT.
// The cosine weights are rounded from Q1.30 values to the configured
// fraction width when they are looked up.
// ----------------------------------------------------------------------------
package idct_pkg;

    localparam int COEFF_WIDTH   = 12;
    localparam int COS_FRAC_BITS = 14;
    localparam int MID_WIDTH     = 16;
    localparam int ACC_WIDTH     = 32;
    localparam int N             = 8;
    localparam int NN            = 64;
    localparam int COS_W         = 20;   // covers Q1.18 plus sign

    // cos(k*pi/16) in Q1.30, k = 0..8
    function automatic logic signed [31:0] cos_q30(input logic [3:0] k);
        case (k)
            4'd0:    cos_q30 = 32'sd1073741824;
            4'd1:    cos_q30 = 32'sd1053110176;
            4'd2:    cos_q30 = 32'sd992008094;
            4'd3:    cos_q30 = 32'sd892783698;
            4'd4:    cos_q30 = 32'sd759250125;
            4'd5:    cos_q30 = 32'sd596538995;
            4'd6:    cos_q30 = 32'sd410903207;
            4'd7:    cos_q30 = 32'sd209476638;
            default: cos_q30 = 32'sd0;
        endcase
    endfunction

    // Rounded cosine in Q1.f, f = frac bits.
    function automatic logic signed [COS_W-1:0] round_cos(input logic [3:0] k,
                                                         input int f);
        logic signed [32:0] t;
        t = 33'(cos_q30(k)) + (33'sd1 <<< (29 - f));
        round_cos = COS_W'(t >>> (30 - f));
    endfunction

    // Basis weight for spatial index x and frequency u.
    function automatic logic signed [COS_W-1:0] weight(input logic [2:0] x,
                                                      input logic [2:0] u,
                                                      input int f);
        logic [4:0] m;
        logic [7:0] p;
        p = 8'(({5'd0, x} * 6'd2 + 6'd1) * {3'd0, u});
        m = p[4:0];
        if (m > 5'd16) m = 5'd0 - m;
        if (u == 3'd0)
            weight = round_cos(4'd4, f);
        else if (m <= 5'd8)
            weight = round_cos(m[3:0], f);
        else
            weight = -round_cos(4'(5'd16 - m), f);
    endfunction

endpackage

// File: src/idct_8x8_clamped.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idct_8x8_clamped: 8x8 2D inverse DCT, row-column, clamped pixel output.
// Coefficients are stored, then a column pass and a row pass run on a chain
// of eight MAC cells; pixels are then played out one per cycle.
// ----------------------------------------------------------------------------
//   channel   | ports                         | handshake
//   coeff in  | i_coeff                       | start & !busy
//   pixel out | o_pixel, o_last_of_block      | o_valid, one cycle, no stall
//
// Coefficients are taken one per cycle while start is high and busy is low.
// After the 64th, each pass runs 8 lines x (8 feed + 8 drain) = 128 steps,
// then holds the last step for the chain to drain; the row pass follows the
// column pass, and pixel output follows the row pass. busy stays high from
// the 64th request to the end of pixel output; the last pixel shows in the
// first idle cycle. One memory read per cycle feeds the cell chain.
// Synchronous active-low reset clears the counters and the state.
// ----------------------------------------------------------------------------
module idct_8x8_clamped #(
    parameter int COEFF_WIDTH   = idct_pkg::COEFF_WIDTH,
    parameter int COS_FRAC_BITS = idct_pkg::COS_FRAC_BITS,
    parameter int MID_WIDTH     = idct_pkg::MID_WIDTH,
    parameter int ACC_WIDTH     = idct_pkg::ACC_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [COEFF_WIDTH-1:0] i_coeff,
    output logic                   o_valid,
    output logic [7:0]             o_pixel,
    output logic                   o_last_of_block
);
    localparam int DW = (COEFF_WIDTH > MID_WIDTH) ? COEFF_WIDTH : MID_WIDTH;
    localparam logic [2:0] S_LOAD = 3'd0, S_COL = 3'd1, S_ROW = 3'd2, S_OUT = 3'd3;

    logic [2:0] r_state;
    logic [5:0] r_load;
    logic [6:0] r_cnt;      // step inside a pass: line*16 + phase
    logic [5:0] r_ocnt;
    logic       r_valid;
    logic [7:0] r_pix;
    logic       r_last;

    logic signed [COEFF_WIDTH-1:0] coeff_mem [0:63];
    logic signed [MID_WIDTH-1:0]   tr_mem    [0:63];
    logic [7:0]                    pix_mem   [0:63];

    // feed: phase 0..7 reads one sample per cycle; phase 8..15 drains
    logic [2:0] line, phase;
    logic       feeding;
    assign line    = r_cnt[6:4];
    assign phase   = r_cnt[2:0];
    assign feeding = !r_cnt[3];

    logic signed [DW-1:0] r_rd;
    logic [2:0]           r_rfreq;
    logic                 r_rvalid;
    logic                 r_rfirst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= (r_state == S_COL || r_state == S_ROW) && feeding;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rfirst <= phase == 3'd0;
        r_rfreq  <= phase;
        if (r_state == S_COL)
            r_rd <= DW'(coeff_mem[{phase, line}]);   // column 'line', row phase
        else
            r_rd <= DW'(tr_mem[{line, phase}]);
    end

    // chain: sample enters cell 0 and shifts one cell per cycle
    logic signed [DW-1:0]        c_data [0:8];
    logic [2:0]                  c_freq [0:8];
    logic [7:0]                  c_en;
    logic [7:0]                  c_first;
    logic signed [ACC_WIDTH-1:0] c_acc  [0:7];
    logic [6:0]                  r_en_d, r_first_d;

    assign c_data[0]  = r_rd;
    assign c_freq[0]  = r_rfreq;
    assign c_en[0]    = r_rvalid;
    assign c_first[0] = r_rfirst;
    assign c_en[7:1]    = r_en_d;
    assign c_first[7:1] = r_first_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_d    <= '0;
            r_first_d <= '0;
        end else begin
            r_en_d    <= c_en[6:0];
            r_first_d <= c_first[6:0];
        end
    end

    genvar g;
    generate
        for (g = 0; g < 8; g++) begin : g_cell
            idct_cell #(
                .IN_W(DW), .FRAC(COS_FRAC_BITS), .ACC_W(ACC_WIDTH), .IDX(3'(g))
            ) u_cell (
                .i_clk (i_clk),
                .i_clr (c_first[g]),
                .i_en  (c_en[g]),
                .i_freq(c_freq[g]),
                .i_data(c_data[g]),
                .o_data(c_data[g+1]),
                .o_freq(c_freq[g+1]),
                .o_acc (c_acc[g])
            );
        end
    endgenerate

    // result of cell k is ready when its 8th term is in: track via counter
    logic [3:0] r_wcnt [0:7];
    logic [2:0] r_wline [0:7];
    logic [2:0] r_line_d;
    logic [2:0] c_line [0:7];
    always_ff @(posedge i_clk) begin
        r_line_d <= line;
    end

    // line number travels with the first term of each sum
    always_comb begin
        c_line[0] = r_line_d;
        for (int i = 1; i < 8; i++)
            c_line[i] = r_wline[i-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_wcnt[i] <= '0;
        end else begin
            for (int i = 0; i < 8; i++) begin
                if (c_en[i]) begin
                    if (c_first[i]) begin
                        r_wcnt[i]  <= 4'd1;
                        r_wline[i] <= c_line[i];
                    end else begin
                        r_wcnt[i] <= r_wcnt[i] + 4'd1;
                    end
                end else if (r_wcnt[i] == 4'd8) begin
                    r_wcnt[i] <= '0;
                end
            end
        end
    end

    // cells finish one cycle apart, so at most one sum is written per cycle
    logic                        wr_en;
    logic [2:0]                  wr_cell;
    logic [2:0]                  wr_line;
    logic signed [ACC_WIDTH-1:0] wr_acc;
    always_comb begin
        wr_en   = 1'b0;
        wr_cell = '0;
        for (int i = 0; i < 8; i++) begin
            if (r_wcnt[i] == 4'd8 && !(c_en[i] && !c_first[i])) begin
                wr_en   = 1'b1;
                wr_cell = 3'(i);
            end
        end
        wr_acc  = c_acc[wr_cell];
        wr_line = r_wline[wr_cell];
    end

    logic signed [ACC_WIDTH:0] hv;
    logic signed [ACC_WIDTH:0] rr;
    assign hv = (ACC_WIDTH+1)'(wr_acc) + ((ACC_WIDTH+1)'(1) <<< COS_FRAC_BITS);
    assign rr = hv >>> (COS_FRAC_BITS + 1);

    // write results in the cycle after the last term
    logic r_pass_col;
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (r_pass_col) begin
                if (rr > (ACC_WIDTH+1)'((1 <<< (MID_WIDTH-1)) - 1))
                    tr_mem[{wr_cell, wr_line}] <= MID_WIDTH'((1 <<< (MID_WIDTH-1)) - 1);
                else if (rr < -(ACC_WIDTH+1)'(1 <<< (MID_WIDTH-1)))
                    tr_mem[{wr_cell, wr_line}] <= MID_WIDTH'(-(1 <<< (MID_WIDTH-1)));
                else
                    tr_mem[{wr_cell, wr_line}] <= MID_WIDTH'(rr);
            end else begin
                if (rr > (ACC_WIDTH+1)'(255))
                    pix_mem[{wr_line, wr_cell}] <= 8'd255;
                else if (rr < 0)
                    pix_mem[{wr_line, wr_cell}] <= 8'd0;
                else
                    pix_mem[{wr_line, wr_cell}] <= 8'(rr);
            end
        end
    end

    // load
    always_ff @(posedge i_clk)
        if (start && !busy) coeff_mem[r_load] <= i_coeff;

    // hold the last step so the chain drains before the next pass
    logic [7:0] r_tail;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load     <= '0;
            r_cnt      <= '0;
            r_tail     <= '0;
            r_ocnt     <= '0;
            r_valid    <= 1'b0;
            r_pass_col <= 1'b1;
        end else begin
            r_valid <= (r_state == S_OUT);
            case (r_state)
                S_LOAD: begin
                    if (start) begin
                        r_load <= r_load + 6'd1;
                        if (r_load == 6'd63) begin
                            r_state    <= S_COL;
                            r_cnt      <= '0;
                            r_tail     <= '0;
                            r_pass_col <= 1'b1;
                        end
                    end
                end
                S_COL, S_ROW: begin
                    if (r_cnt != 7'd127) r_cnt <= r_cnt + 7'd1;
                    else if (r_tail != 8'd24) r_tail <= r_tail + 8'd1;
                    else begin
                        r_cnt  <= '0;
                        r_tail <= '0;
                        if (r_state == S_COL) begin
                            r_state    <= S_ROW;
                            r_pass_col <= 1'b0;
                        end else begin
                            r_state <= S_OUT;
                            r_ocnt  <= '0;
                        end
                    end
                end
                S_OUT: begin
                    r_ocnt <= r_ocnt + 6'd1;
                    if (r_ocnt == 6'd63) r_state <= S_LOAD;
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix  <= pix_mem[r_ocnt];
        r_last <= r_ocnt == 6'd63;
    end

    assign busy            = r_state != S_LOAD;
    assign o_valid         = r_valid;
    assign o_pixel         = r_pix;
    assign o_last_of_block = r_last;

    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_of_block && o_valid |=> !o_valid) else $error("last not final");
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy || o_last_of_block) else $error("output while idle");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> $stable(r_load)) else $error("load moved while busy");
endmodule

// File: src/idct_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idct_cell: one multiply-accumulate cell of the IDCT chain.
// Each cell owns one output index and sees the input samples pass by
// along the chain; it adds sample times its own weight each enabled cycle.
// ----------------------------------------------------------------------------
module idct_cell #(
    parameter int IN_W   = 16,
    parameter int FRAC   = idct_pkg::COS_FRAC_BITS,
    parameter int ACC_W  = idct_pkg::ACC_WIDTH,
    parameter logic [2:0] IDX = 3'd0
) (
    input  logic                    i_clk,
    input  logic                    i_clr,     // first term of a sum
    input  logic                    i_en,
    input  logic [2:0]              i_freq,    // frequency of incoming sample
    input  logic signed [IN_W-1:0]  i_data,
    output logic signed [IN_W-1:0]  o_data,    // passed to the neighbor
    output logic [2:0]              o_freq,
    output logic signed [ACC_W-1:0] o_acc
);
    localparam int PW = IN_W + idct_pkg::COS_W;
    localparam int SW = (PW > ACC_W ? PW : ACC_W) + 1;

    logic signed [ACC_W-1:0] r_acc;
    logic signed [IN_W-1:0]  r_data;
    logic [2:0]              r_freq;
    logic signed [PW-1:0]    prod;
    logic signed [SW-1:0]    sum;
    logic signed [SW-1:0]    hi, lo;
    logic signed [ACC_W-1:0] n_acc;

    assign prod = PW'(i_data) * PW'(idct_pkg::weight(IDX, i_freq, FRAC));
    assign sum  = (i_clr ? SW'(0) : SW'(r_acc)) + SW'(prod);
    assign hi   = SW'({1'b0, {(ACC_W-1){1'b1}}});
    assign lo   = -hi - SW'(1);

    always_comb begin
        if (sum > hi)      n_acc = ACC_W'(hi);
        else if (sum < lo) n_acc = ACC_W'(lo);
        else               n_acc = ACC_W'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc  <= n_acc;
            r_data <= i_data;
            r_freq <= i_freq;
        end
    end

    assign o_acc  = r_acc;
    assign o_data = r_data;
    assign o_freq = r_freq;
endmodule

// File: tb/tb_idct_8x8_clamped.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_idct_8x8_clamped: self-checking bench for the 8x8 clamped IDCT.
// Coefficient requests are sent with random or zero gaps; a behavioral
// model of the two-pass IDCT, or a typed pixel value, predicts each
// 64-pixel block, which is checked pixel by pixel against the output strobe.
// ----------------------------------------------------------------------------
module tb_idct_8x8_clamped;

    localparam int  COEFF_WIDTH   = idct_pkg::COEFF_WIDTH;
    localparam int  COS_FRAC_BITS = idct_pkg::COS_FRAC_BITS;
    localparam int  MID_WIDTH     = idct_pkg::MID_WIDTH;
    localparam int  ACC_WIDTH     = idct_pkg::ACC_WIDTH;

    localparam int  GAP_MAX    = 10;
    localparam int  N_DIR      = 5;
    localparam int  RAND_ITEMS = 128;
    localparam int  DRAIN_CYC  = 400;
    localparam longint CYC_LIMIT = 300000;

    // directed block patterns
    typedef enum int {
        PAT_FILL,       // every coefficient = val
        PAT_DC_ONLY,    // coefficient 0 = val, rest zero
        PAT_ONE_AC,     // coefficient idx = val, rest zero
        PAT_ALT         // even positions val, odd positions ~val
    } t_pattern;

    typedef struct {
        t_pattern          pat;
        logic signed [COEFF_WIDTH-1:0] val;
        int                idx;
        int                exp_pixel;   // -1: use the model
    } t_block_row;

    typedef struct {
        logic [7:0] pixel;
        logic       last;
    } t_pixel_exp;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [COEFF_WIDTH-1:0] i_coeff;
    logic                   o_valid;
    logic [7:0]             o_pixel;
    logic                   o_last_of_block;

    idct_8x8_clamped i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_coeff        (i_coeff),
        .o_valid        (o_valid),
        .o_pixel        (o_pixel),
        .o_last_of_block(o_last_of_block)
    );

    t_block_row dir_blocks[N_DIR] = '{
        '{PAT_FILL,    12'sd0,     0,  0},
        '{PAT_DC_ONLY, 12'sd2047,  0,  255},
        '{PAT_DC_ONLY, 12'sh800,   0,  0},
        '{PAT_ONE_AC,  12'sd1000,  9,  -1},
        '{PAT_ALT,     12'sh555,   0,  -1}
    };

    longint     basis[8][8];    // [spatial][frequency], Q1.14
    longint     coeff_buf[64];
    int         load_idx;
    t_pixel_exp pixel_q[$];
    int         typed_pixel;    // -1 when the block's pixels are not typed in
    int         n_fail;
    longint     n_cyc;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint sat_to(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // floor((acc + 2^F) / 2^(F+1))
    function automatic longint half_round(longint acc);
        return (acc + (longint'(1) <<< COS_FRAC_BITS)) >>> (COS_FRAC_BITS + 1);
    endfunction

    function automatic void build_basis();
        longint q30[9] = '{1073741824, 1053110176, 992008094, 892783698, 759250125,
                           596538995, 410903207, 209476638, 0};
        longint rc[9];
        int     sh, m;
        sh = 30 - COS_FRAC_BITS;
        foreach (rc[k]) rc[k] = (q30[k] + (longint'(1) <<< (sh - 1))) >>> sh;
        for (int x = 0; x < 8; x++)
            for (int u = 0; u < 8; u++) begin
                m = ((2 * x + 1) * u) % 32;
                if (m > 16) m = 32 - m;
                if (u == 0) basis[x][u] = rc[4];
                else if (m <= 8) basis[x][u] = rc[m];
                else basis[x][u] = -rc[16 - m];
            end
    endfunction

    // column pass into a transpose buffer, row pass to clamped pixels
    function automatic void reconstruct_block();
        longint mid[64];
        longint acc, r;
        t_pixel_exp e;
        for (int y = 0; y < 8; y++)
            for (int u = 0; u < 8; u++) begin
                acc = 0;
                for (int v = 0; v < 8; v++)
                    acc = sat_to(acc + coeff_buf[v*8+u] * basis[y][v], ACC_WIDTH);
                mid[y*8+u] = sat_to(half_round(acc), MID_WIDTH);
            end
        for (int y = 0; y < 8; y++)
            for (int x = 0; x < 8; x++) begin
                acc = 0;
                for (int u = 0; u < 8; u++)
                    acc = sat_to(acc + mid[y*8+u] * basis[x][u], ACC_WIDTH);
                r = half_round(acc);
                if (r > 255) r = 255;
                if (r < 0) r = 0;
                e.pixel = 8'(r);
                if (typed_pixel >= 0) e.pixel = 8'(typed_pixel);
                e.last  = (y == 7 && x == 7);
                pixel_q.push_back(e);
            end
    endfunction

    // accepted requests feed the model
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            coeff_buf[load_idx] = longint'($signed(i_coeff));
            load_idx = (load_idx + 1) % 64;
            if (load_idx == 0) reconstruct_block();
        end
    end

    always @(posedge i_clk) begin
        t_pixel_exp e;
        if (i_rst_n && o_valid) begin
            if (pixel_q.size() == 0) begin
                $error("pixel strobe with nothing expected: pixel %0d", o_pixel);
                n_fail++;
            end else begin
                e = pixel_q.pop_front();
                if (o_pixel !== e.pixel) begin
                    $error("pixel: expected %0d, got %0d", e.pixel, o_pixel);
                    n_fail++;
                end
                if (o_last_of_block !== e.last) begin
                    $error("last_of_block: expected %0d, got %0d", e.last,
                           o_last_of_block);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cyc++;
        if (n_cyc > CYC_LIMIT) begin
            $display("tb_idct_8x8_clamped NOT OK");
            $finish;
        end
    end

    // one request; gap cycles of idle first; held until busy is low
    task automatic send_coeff(logic [COEFF_WIDTH-1:0] c, int gap);
        repeat (gap) @(negedge i_clk);
        start   = 1'b1;
        i_coeff = c;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
        start   = 1'b0;
        i_coeff = COEFF_WIDTH'($urandom);
    endtask

    function automatic logic [COEFF_WIDTH-1:0] rand_coeff(int style);
        case (style)
            0: return COEFF_WIDTH'($urandom);
            1: return COEFF_WIDTH'($signed($urandom_range(0, 64)) - 32);
            default:
                // mostly zero, as in quantized blocks
                return ($urandom_range(0, 3) == 0) ?
                       COEFF_WIDTH'($signed($urandom_range(0, 1024)) - 512) : '0;
        endcase
    endfunction

    initial begin
        logic [COEFF_WIDTH-1:0] c;
        int gap_hi, style;
        n_fail      = 0;
        n_cyc       = 0;
        load_idx    = 0;
        typed_pixel = -1;
        start       = 1'b0;
        i_coeff     = '0;
        i_rst_n     = 1'b0;
        build_basis();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_blocks[b]) begin
            for (int k = 0; k < 64; k++) begin
                case (dir_blocks[b].pat)
                    PAT_FILL:    c = dir_blocks[b].val;
                    PAT_DC_ONLY: c = (k == 0) ? dir_blocks[b].val : '0;
                    PAT_ONE_AC:  c = (k == dir_blocks[b].idx) ? dir_blocks[b].val : '0;
                    default:     c = k[0] ? ~dir_blocks[b].val : dir_blocks[b].val;
                endcase
                // typed value is set before the 64th request completes
                typed_pixel = dir_blocks[b].exp_pixel;
                send_coeff(c, (b % 2) ? $urandom_range(0, GAP_MAX) : 0);
            end
        end

        // hold off until every pixel of the directed blocks is back
        while (pixel_q.size() != 0) @(negedge i_clk);
        typed_pixel = -1;

        gap_hi = 0;
        style  = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 64 == 0) begin
                gap_hi = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
                style  = $urandom_range(0, 2);
            end
            send_coeff(rand_coeff(style), $urandom_range(0, gap_hi));
        end

        while (pixel_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYC) @(negedge i_clk);
        if (n_fail == 0) begin
            $display("tb_idct_8x8_clamped OK");
        end else begin
            $display("tb_idct_8x8_clamped NOT OK");
        end
        $finish;
    end

endmodule
